[rtl/psg_pkg.sv]
// Shared constants, types and tables of the tone and noise sound generator.
package psg_pkg;

    // Phase accumulators hold fractions of one waveform cycle.
    localparam int PHASE_BITS = 32;

    // Input chip clock in hertz; a tone increment is CLK * 2^(PHASE_BITS-5) / (period * rate).
    localparam logic [21:0] CHIP_CLOCK = 22'd3579545;
    localparam int TONE_SHIFT = PHASE_BITS - 5;

    // Divider sizes: the widest dividend is a 22-bit clock shifted by PHASE_BITS-5 or a
    // 17-bit noise rate shifted by the phase width; widest divisor: period * rate (< 2^28).
    localparam int DIV_N_W   = PHASE_BITS + 17;
    localparam int DIV_D_W   = 28;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_N_W - 1);

    localparam logic [DIV_N_W-1:0] TONE_NUM = DIV_N_W'(CHIP_CLOCK) << TONE_SHIFT;

    // Configuration registers and their limits.
    localparam logic       REG_OUT_RATE    = 1'b0;
    localparam logic       REG_ATTENUATION = 1'b1;
    localparam logic [17:0] RATE_LOW    = 18'd8000;
    localparam logic [17:0] RATE_HIGH   = 18'd192000;
    localparam logic [17:0] RATE_RESET  = 18'd48000;
    localparam logic [6:0]  ATT_MAX     = 7'd64;

    // Output scaling: sample = S * (64 - att) * 20000 / 2880 = S * (64 - att) * 125 / 18.
    // The divide by 18 is a multiply by ceil(2^24 / 18) and a shift by 24, exact for
    // products below 2^21; the factor 125 is folded into the constant.
    localparam logic [15:0] FULL_SCALE  = 16'd20000;
    localparam int          SCALE_SHIFT = 24;
    localparam int          SCALE_W     = SCALE_SHIFT + 16;
    localparam logic [26:0] SCALE_RECIP = 27'd116508500;

    // Port byte decoding.
    localparam int          CMD_LATCH_BIT  = 7;
    localparam int          CMD_VOLUME_BIT = 4;
    localparam logic [1:0]  NOISE_CH       = 2'd3;
    localparam logic [1:0]  NOISE_SEL_TONE2 = 2'd3;
    localparam logic [3:0]  VOL_SILENT     = 4'd15;
    localparam logic [14:0] LFSR_SEED      = 15'h4000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TSETUP,
        ST_TDIV,
        ST_TADD,
        ST_NSETUP,
        ST_NDIV,
        ST_NADD,
        ST_SCALE1,
        ST_SCALE2,
        ST_OUT
    } t_state;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic done;   // quotient valid, one-cycle pulse
        logic ovf;    // quotient reached 2^PHASE_BITS or more
    } t_div_stat;

    // Noise rates in tenths of a hertz.
    function automatic logic [16:0] noise_tenths(input logic [1:0] sel);
        logic [16:0] f;
        case (sel)
            2'd0:    f = 17'd69913;
            2'd1:    f = 17'd34956;
            2'd2:    f = 17'd17478;
            default: f = 17'd0;
        endcase
        return f;
    endfunction

endpackage

[rtl/psg_divider.sv]
// Shared restoring divider, one quotient bit per cycle, low phase bits kept plus overflow.
module psg_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [psg_pkg::DIV_N_W-1:0]       i_dividend,
    input  logic [psg_pkg::DIV_D_W-1:0]       i_divisor,
    output logic [psg_pkg::PHASE_BITS-1:0]    o_quotient,
    output psg_pkg::t_div_stat                o_stat
);

    logic [psg_pkg::DIV_N_W-1:0]    r_num, n_num;
    logic [psg_pkg::DIV_D_W-1:0]    r_den;
    logic [psg_pkg::DIV_D_W-1:0]    r_rem, n_rem;
    logic [psg_pkg::PHASE_BITS-1:0] r_quo, n_quo;
    logic                           r_ovf, n_ovf;
    logic [psg_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy, r_done;

    logic [psg_pkg::DIV_D_W:0] trial;
    logic [psg_pkg::DIV_D_W:0] diff;
    logic                      ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_num[psg_pkg::DIV_N_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[psg_pkg::DIV_D_W-1:0] : trial[psg_pkg::DIV_D_W-1:0];
        n_quo = {r_quo[psg_pkg::PHASE_BITS-2:0], ge};
        n_ovf = r_ovf | r_quo[psg_pkg::PHASE_BITS-1];
        n_num = {r_num[psg_pkg::DIV_N_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psg_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_ovf <= n_ovf;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

[rtl/psg_tone_noise_generator.sv]
// Top level of the three-tone, one-noise sound generator with mono sample output.
//
// Two kinds of input word arrive on one channel. A port-byte word (operation 0)
// updates the chip registers: a latch byte (bit 7 set) picks a channel and sets
// its 4-bit volume, its low four tone-period bits or the noise mode; a data byte
// after a tone-period latch sets the upper six period bits of that tone. It
// produces no output word. A sample-request word (operation 1) advances the three
// tone phases, and the noise phase unless noise is silent, by one output period
// and yields one 16-bit signed sample, clamped to +-20000. Every increment is
// worked out by a single restoring divider that delivers one quotient bit per
// clock, 49 steps per division: one division per tone channel and one for noise
// rates 0..2 (rate 3 reuses tone 2's result, and a silent noise channel skips it).
// The final output scaling is a reciprocal multiply. Each tone passes through
// setup, division and phase update; a sample request holds the input stall high
// through the tone steps, any noise step and the scaling until the sample is
// loaded, and the last step waits while an uncollected earlier sample remains.
// The finished sample sits in an output register, so the next word is taken
// while it waits to be collected. Output-rate writes outside 8000..192000 are
// ignored; attenuation above 64 mutes the output. Configuration must be written
// by the user only while no sample request is in flight; the block does not enforce this.
module psg_tone_noise_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data,
    // output word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_sample,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [17:0] i_cfg_data
);

    psg_pkg::t_state r_state, n_state;

    // configuration
    logic [17:0] r_rate;
    logic [6:0]  r_att;

    // chip registers
    logic [3:0]  r_tone_lo [3];
    logic [5:0]  r_tone_hi [3];
    logic [3:0]  r_vol     [4];
    logic [7:0]  r_latch;
    logic [2:0]  r_noise_ctl;
    logic [14:0] r_lfsr;
    logic [psg_pkg::PHASE_BITS-1:0] r_phase [4];

    // sample work registers
    logic [1:0]         r_ch;
    logic signed [6:0]  r_sum;
    logic [12:0]        r_prod;
    logic               r_neg;
    logic [15:0]        r_mag;
    logic               r_out_valid;
    logic signed [15:0] r_sample;

    // divider hookup
    logic                           div_start;
    logic [psg_pkg::DIV_N_W-1:0]    div_num;
    logic [psg_pkg::DIV_D_W-1:0]    div_den;
    logic [psg_pkg::PHASE_BITS-1:0] div_quo;
    psg_pkg::t_div_stat             div_stat;

    psg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    logic in_acc;
    logic out_free;
    logic [9:0]  period;
    logic [9:0]  period_nz;
    logic [3:0]  amp;
    logic [psg_pkg::PHASE_BITS-1:0] tone_phase;
    logic [psg_pkg::PHASE_BITS:0]   noise_sum;
    logic          noise_carry;
    logic          fb;
    logic [14:0]   lfsr_next;
    logic [3:0]    noise_amp;
    logic [5:0]    sum_mag;
    logic [6:0]    att_c;
    logic [6:0]    att_gain;
    logic [psg_pkg::SCALE_W-1:0] scale_prod;
    logic [15:0]   out_mag;
    logic [1:0]    wr_ch;
    logic [1:0]    latch_ch;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != psg_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    assign wr_ch    = i_data[6:5];
    assign latch_ch = r_latch[6:5];

    // Datapath helpers for the step currently under way.
    always_comb begin
        period     = {r_tone_hi[r_ch], r_tone_lo[r_ch]};
        period_nz  = (period == 10'd0) ? 10'd1 : period;
        amp        = psg_pkg::VOL_SILENT - r_vol[r_ch];
        tone_phase = r_phase[r_ch] + div_quo;

        // Noise: carry out of the phase, or an increment of a full cycle or more.
        noise_sum   = {1'b0, r_phase[3]} + {1'b0, div_quo};
        noise_carry = noise_sum[psg_pkg::PHASE_BITS] | div_stat.ovf;
        fb          = r_lfsr[0] ^ (r_noise_ctl[2] & r_lfsr[1]);
        lfsr_next   = noise_carry ? {fb, r_lfsr[14:1]} : r_lfsr;
        noise_amp   = psg_pkg::VOL_SILENT - r_vol[3];

        sum_mag  = r_sum[6] ? 6'(-r_sum) : r_sum[5:0];
        att_c    = (r_att > psg_pkg::ATT_MAX) ? psg_pkg::ATT_MAX : r_att;
        att_gain = psg_pkg::ATT_MAX - att_c;

        // Scale the magnitude, so the quotient truncates toward zero.
        scale_prod = psg_pkg::SCALE_W'(r_prod) * psg_pkg::SCALE_W'(psg_pkg::SCALE_RECIP);
        out_mag    = (r_mag > psg_pkg::FULL_SCALE) ? psg_pkg::FULL_SCALE : r_mag;
    end

    // Sequencer: next state and divider requests.
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = psg_pkg::TONE_NUM;
        div_den   = psg_pkg::DIV_D_W'(period_nz) * psg_pkg::DIV_D_W'(r_rate);
        case (r_state)
            psg_pkg::ST_IDLE: begin
                if (in_acc && i_operation) begin
                    n_state = psg_pkg::ST_TSETUP;
                end
            end
            psg_pkg::ST_TSETUP: begin
                div_start = 1'b1;
                n_state   = psg_pkg::ST_TDIV;
            end
            psg_pkg::ST_TDIV: begin
                if (div_stat.done) begin
                    n_state = psg_pkg::ST_TADD;
                end
            end
            psg_pkg::ST_TADD: begin
                n_state = (r_ch == 2'd2) ? psg_pkg::ST_NSETUP : psg_pkg::ST_TSETUP;
            end
            psg_pkg::ST_NSETUP: begin
                if (r_vol[3] == psg_pkg::VOL_SILENT) begin
                    n_state = psg_pkg::ST_SCALE1;
                end else if (r_noise_ctl[1:0] == psg_pkg::NOISE_SEL_TONE2) begin
                    // tone 2's increment is still in the divider
                    n_state = psg_pkg::ST_NADD;
                end else begin
                    div_start = 1'b1;
                    div_num   = psg_pkg::DIV_N_W'(psg_pkg::noise_tenths(r_noise_ctl[1:0]))
                                << psg_pkg::PHASE_BITS;
                    div_den   = psg_pkg::DIV_D_W'(r_rate) * psg_pkg::DIV_D_W'(4'd10);
                    n_state   = psg_pkg::ST_NDIV;
                end
            end
            psg_pkg::ST_NDIV: begin
                if (div_stat.done) begin
                    n_state = psg_pkg::ST_NADD;
                end
            end
            psg_pkg::ST_NADD: begin
                n_state = psg_pkg::ST_SCALE1;
            end
            psg_pkg::ST_SCALE1: begin
                n_state = psg_pkg::ST_SCALE2;
            end
            psg_pkg::ST_SCALE2: begin
                n_state = psg_pkg::ST_OUT;
            end
            psg_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = psg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= psg_pkg::RATE_RESET;
            r_att  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psg_pkg::REG_OUT_RATE: begin
                    // drop rates outside the supported range
                    if (i_cfg_data >= psg_pkg::RATE_LOW && i_cfg_data <= psg_pkg::RATE_HIGH) begin
                        r_rate <= i_cfg_data;
                    end
                end
                psg_pkg::REG_ATTENUATION: begin
                    r_att <= i_cfg_data[6:0];
                end
                default: begin
                    r_att <= r_att;
                end
            endcase
        end
    end

    // Chip registers, phases, noise shift register and sample work state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_tone_lo[i] <= '0;
                r_tone_hi[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_vol[i]   <= psg_pkg::VOL_SILENT;
                r_phase[i] <= '0;
            end
            r_latch     <= '0;
            r_noise_ctl <= '0;
            r_lfsr      <= psg_pkg::LFSR_SEED;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_sum       <= '0;
        end else begin
            // Load a finished sample, or drop the output word once it is taken.
            if (r_state == psg_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                psg_pkg::ST_IDLE: begin
                    r_ch  <= '0;
                    r_sum <= '0;
                    if (in_acc && !i_operation) begin
                        if (i_data[psg_pkg::CMD_LATCH_BIT]) begin
                            r_latch <= i_data;
                            if (i_data[psg_pkg::CMD_VOLUME_BIT]) begin
                                r_vol[wr_ch] <= i_data[3:0];
                            end else if (wr_ch != psg_pkg::NOISE_CH) begin
                                r_tone_lo[wr_ch] <= i_data[3:0];
                            end else begin
                                r_noise_ctl <= i_data[2:0];
                            end
                        end else if (!r_latch[psg_pkg::CMD_VOLUME_BIT]
                                     && latch_ch != psg_pkg::NOISE_CH) begin
                            // data byte after a volume or noise latch is ignored
                            r_tone_hi[latch_ch] <= i_data[5:0];
                        end
                    end
                end
                psg_pkg::ST_TADD: begin
                    r_phase[r_ch] <= tone_phase;
                    r_sum <= tone_phase[psg_pkg::PHASE_BITS-1] ? r_sum - 7'(amp)
                                                               : r_sum + 7'(amp);
                    r_ch  <= r_ch + 1'b1;
                end
                psg_pkg::ST_NADD: begin
                    r_phase[3] <= noise_sum[psg_pkg::PHASE_BITS-1:0];
                    r_lfsr     <= lfsr_next;
                    r_sum <= lfsr_next[0] ? r_sum + 7'(noise_amp) : r_sum - 7'(noise_amp);
                end
                default: begin
                    r_ch <= r_ch;
                end
            endcase
        end
    end

    // Sample payload: scale product, sign and final clamp.
    always_ff @(posedge i_clk) begin
        if (r_state == psg_pkg::ST_SCALE1) begin
            r_prod <= 13'(sum_mag) * 13'(att_gain);
            r_neg  <= r_sum[6];
        end
        if (r_state == psg_pkg::ST_SCALE2) begin
            r_mag <= scale_prod[psg_pkg::SCALE_W-1 -: 16];
        end
        if (r_state == psg_pkg::ST_OUT && out_free) begin
            r_sample <= r_neg ? -$signed(out_mag) : $signed(out_mag);
        end
    end

endmodule

[rtl/psg_checker.sv]
// Port-level checks of the sound generator, bound to its top level.
module psg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_operation,
    input logic [7:0]  i_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic signed [15:0] o_sample,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_cfg_index,
    input logic [17:0] i_cfg_data
);

    // After a port-byte word the input is not stalled in the following cycle.
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_operation) |=> !o_in_stall)
        else $error("port byte write held the input channel");

    // A sample request occupies the block.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation) |=> o_in_stall)
        else $error("sample request did not stall the input");

    // Samples stay inside full scale.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample >= -16'sd20000 && o_sample <= 16'sd20000))
        else $error("sample outside full scale");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample)))
        else $error("stalled output word changed");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench of the tone and noise sound generator, with its own sample predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes of an input word.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Predictor constants.
    localparam logic [63:0] CHIP_HZ      = 64'd3579545;
    localparam int          TONE_FRAC    = 27;
    localparam int          FRAC_BITS    = 32;
    localparam int          OUT_LIMIT    = 20000;
    localparam int          OUT_DIVISOR  = 2880;
    localparam logic [17:0] RATE_MIN_HZ  = 18'd8000;
    localparam logic [17:0] RATE_MAX_HZ  = 18'd192000;

    // Run control.
    localparam int LATENCY_CYCLES = 300;    // one sample request, with margin
    localparam int HOLD_CYCLES    = 3000;   // long output hold-off
    localparam int WATCHDOG_LIMIT = 20000;  // cycles without any handshake

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } port_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_operation = 1'b0;
    logic [7:0] i_data = 8'd0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [15:0] o_sample;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [17:0] i_cfg_data = 18'd0;

    psg_tone_noise_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operation(i_operation),
        .i_data     (i_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_sample   (o_sample),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state: a shadow of the chip registers, phases and noise shifter.
    logic [17:0] rate_q = 18'd48000;
    logic [6:0]  atten_q = 7'd0;
    logic [9:0]  period_q [3] = '{default: 10'd0};
    logic [3:0]  volume_q [4] = '{default: 4'd15};
    logic [7:0]  latch_q = 8'd0;
    logic [2:0]  noise_ctl_q = 3'd0;
    logic [14:0] lfsr_q = 15'h4000;
    logic [31:0] phase_q [4] = '{default: 32'd0};

    port_word_t          word_q[$];          // words waiting to be offered
    logic signed [15:0]  sample_forecast[$]; // predicted samples, oldest first

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int words_taken = 0;
    int samples_checked = 0;
    int mismatches = 0;

    // Phase increment of a tone; period 0 behaves as period 1.
    function automatic logic [63:0] tone_step(input logic [9:0] period);
        logic [63:0] divisor;
        divisor = ((period == 10'd0) ? 64'd1 : 64'(period)) * 64'(rate_q);
        return (CHIP_HZ << TONE_FRAC) / divisor;
    endfunction

    function automatic logic [63:0] noise_step(input logic [1:0] sel);
        logic [63:0] tenths;
        case (sel)
            2'd0:    tenths = 64'd69913;
            2'd1:    tenths = 64'd34956;
            default: tenths = 64'd17478;
        endcase
        return (tenths << FRAC_BITS) / (64'(rate_q) * 64'd10);
    endfunction

    function automatic void apply_port_byte(input logic [7:0] b);
        logic [1:0] ch;
        if (b[7]) begin
            latch_q = b;
            ch = b[6:5];
            if (b[4]) begin
                volume_q[ch] = b[3:0];
            end else if (ch != psg_pkg::NOISE_CH) begin
                period_q[ch] = {period_q[ch][9:4], b[3:0]};
            end else begin
                noise_ctl_q = b[2:0];
            end
        end else begin
            ch = latch_q[6:5];
            // Data bytes only reach a latched tone period.
            if (!latch_q[4] && ch != psg_pkg::NOISE_CH) begin
                period_q[ch] = {b[5:0], period_q[ch][3:0]};
            end
        end
    endfunction

    // Advance tone phases, and noise unless silent, by one output period; form the mono sample.
    function automatic logic signed [15:0] predict_sample();
        int          acc;
        int          level;
        int          att;
        longint      scaled;
        logic [63:0] sum;
        logic [63:0] inc;
        logic        fb;
        acc = 0;
        for (int ch = 0; ch < 3; ch++) begin
            phase_q[ch] = 32'(64'(phase_q[ch]) + tone_step(period_q[ch]));
            level = 15 - int'(volume_q[ch]);
            acc += phase_q[ch][31] ? -level : level;
        end
        if (volume_q[psg_pkg::NOISE_CH] != psg_pkg::VOL_SILENT) begin
            inc = (noise_ctl_q[1:0] == psg_pkg::NOISE_SEL_TONE2)
                  ? tone_step(period_q[2]) : noise_step(noise_ctl_q[1:0]);
            sum = 64'(phase_q[psg_pkg::NOISE_CH]) + inc;
            phase_q[psg_pkg::NOISE_CH] = sum[31:0];
            // One shift per carry, however large the increment.
            if (sum[63:32] != 32'd0) begin
                fb = lfsr_q[0] ^ (noise_ctl_q[2] & lfsr_q[1]);
                lfsr_q = {fb, lfsr_q[14:1]};
            end
            level = 15 - int'(volume_q[psg_pkg::NOISE_CH]);
            acc += lfsr_q[0] ? level : -level;
        end
        att = (atten_q > 7'd64) ? 64 : int'(atten_q);
        scaled = longint'(acc) * (64 - att) * OUT_LIMIT / OUT_DIVISOR;
        if (scaled > OUT_LIMIT) scaled = OUT_LIMIT;
        if (scaled < -OUT_LIMIT) scaled = -OUT_LIMIT;
        return 16'(scaled);
    endfunction

    task automatic log_failure(input string what, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        end
    endtask

    // Input driver: predict each accepted word, then offer the next one or idle.
    always @(posedge i_clk) begin : drive_words
        port_word_t w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                words_taken++;
                if (i_operation == OP_SAMPLE) begin
                    sample_forecast.push_back(predict_sample());
                end else begin
                    apply_port_byte(i_data);
                end
            end
            // Hold a stalled word; otherwise pick the next one or go idle.
            if (!i_in_valid || !o_in_stall) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = word_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= w.op;
                    i_data      <= w.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each accepted sample with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                samples_checked++;
                if (sample_forecast.size() == 0) begin
                    log_failure("unexpected sample", 16'sd0, o_sample);
                end else if (o_sample !== sample_forecast[0]) begin
                    log_failure("sample mismatch", sample_forecast[0], o_sample);
                    void'(sample_forecast.pop_front());
                end else begin
                    void'(sample_forecast.pop_front());
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long output hold-off, counted here so the sender keeps running meanwhile.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void push_word(input logic op, input logic [7:0] value);
        word_q.push_back('{op: op, value: value});
    endfunction

    // Queue one random command: mostly well-formed writes and sample requests.
    function automatic int push_random_command();
        int unsigned pick;
        logic [1:0]  ch;
        logic [9:0]  period;
        pick = $urandom_range(99);
        ch = 2'($urandom_range(2));
        period = 10'($urandom);
        if (pick < 45) begin
            push_word(OP_SAMPLE, 8'($urandom));
            return 1;
        end else if (pick < 67) begin
            // Full tone period: latch with the low bits, then a data byte.
            push_word(OP_WRITE, {1'b1, ch, 1'b0, period[3:0]});
            push_word(OP_WRITE, {1'b0, 1'($urandom), period[9:4]});
            return 2;
        end else if (pick < 80) begin
            push_word(OP_WRITE, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
            return 1;
        end else if (pick < 88) begin
            push_word(OP_WRITE, {1'b1, psg_pkg::NOISE_CH, 1'b0, 4'($urandom)});
            return 1;
        end
        push_word(OP_WRITE, 8'($urandom));
        return 1;
    endfunction

    task automatic queue_random(input int count);
        int n;
        n = 0;
        @(negedge i_clk);
        while (n < count) n += push_random_command();
    endtask

    // Wait until every word went in and every sample came out, then let the block settle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (word_q.size() != 0 || i_in_valid || sample_forecast.size() != 0);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [17:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (index == psg_pkg::REG_OUT_RATE) begin
            // Out-of-range rates are dropped.
            if (value >= RATE_MIN_HZ && value <= RATE_MAX_HZ) rate_q = value;
        end else begin
            atten_q = value[6:0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender rarely idles, receiver stalls most of the time.
        set_idling(7, 81);
        @(negedge i_clk);
        push_word(OP_SAMPLE, 8'h00);    // silent chip after reset
        push_word(OP_WRITE,  8'h90);    // tone 0 loud
        push_word(OP_WRITE,  8'h8F);
        push_word(OP_WRITE,  8'h3F);    // tone 0 longest period
        push_word(OP_WRITE,  8'hB0);    // tone 1 loud, period zero acts as one
        push_word(OP_WRITE,  8'hDA);
        push_word(OP_WRITE,  8'hC5);
        push_word(OP_WRITE,  8'h41);    // data byte with bit 6 set
        push_word(OP_SAMPLE, 8'hFF);    // data field ignored on a request
        push_word(OP_WRITE,  8'hE7);    // white noise clocked by tone 2
        push_word(OP_WRITE,  8'hF0);
        push_word(OP_SAMPLE, 8'h00);
        push_word(OP_WRITE,  8'h5A);    // data after a noise latch: dropped
        push_word(OP_WRITE,  8'hF3);
        push_word(OP_WRITE,  8'h2C);    // data after a volume latch: dropped
        push_word(OP_WRITE,  8'hE4);    // white noise, fastest rate
        push_word(OP_SAMPLE, 8'h80);
        push_word(OP_WRITE,  8'hE1);    // periodic noise, middle rate
        push_word(OP_SAMPLE, 8'h7F);
        push_word(OP_WRITE,  8'hE2);    // slowest noise rate
        push_word(OP_SAMPLE, 8'h01);
        push_word(OP_WRITE,  8'hFF);    // noise silent
        push_word(OP_SAMPLE, 8'hAA);
        push_word(OP_WRITE,  8'h9F);    // tone 0 silent
        push_word(OP_SAMPLE, 8'h55);
        queue_random(120);
        wait_drained();

        // Lowest rate gives huge increments; swap the idling roles.
        write_register(psg_pkg::REG_OUT_RATE, 18'd8000);
        write_register(psg_pkg::REG_ATTENUATION, 18'd0);
        set_idling(81, 7);
        queue_random(60);
        wait_drained();     // sender pauses until every sample is back
        queue_random(60);
        wait_drained();

        // Highest rate with attenuation past the mute point.
        write_register(psg_pkg::REG_OUT_RATE, 18'd192000);
        write_register(psg_pkg::REG_ATTENUATION, 18'd100);
        queue_random(30);
        wait_drained();

        // Rates outside the legal range must be dropped; full attenuation.
        write_register(psg_pkg::REG_OUT_RATE, 18'd7999);
        write_register(psg_pkg::REG_OUT_RATE, 18'd192001);
        write_register(psg_pkg::REG_OUT_RATE, 18'd0);
        write_register(psg_pkg::REG_ATTENUATION, 18'd64);
        set_idling(0, 0);
        queue_random(20);
        wait_drained();

        // Long output hold while words keep coming, so the input backs up.
        write_register(psg_pkg::REG_OUT_RATE, 18'd44100);
        write_register(psg_pkg::REG_ATTENUATION, 18'd17);
        @(negedge i_clk);
        hold_requests++;
        queue_random(130);
        wait_drained();

        // All-ones rate is dropped; attenuation keeps only its low seven bits.
        write_register(psg_pkg::REG_OUT_RATE, 18'h3FFFF);
        write_register(psg_pkg::REG_ATTENUATION, 18'h3FF85);
        queue_random(120);
        wait_drained();

        $display("Run covered %0d input words and %0d samples over six register settings,",
                 words_taken, samples_checked);
        $display("with both idling mixes, a long output hold and a drain pause.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d failures", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[psg_tone_noise_generator.f]
rtl/psg_pkg.sv
rtl/psg_divider.sv
rtl/psg_tone_noise_generator.sv
rtl/psg_checker.sv
dv/tb_top.sv
